// File: hdl/sgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants for the SGR pen attribute parser: payload
// structs, the command format between decoder and executor, and SGR codes.
// ----------------------------------------------------------------------------
package sgr_pkg;

   // input item
   typedef struct packed {
      logic [15:0] param_value;
      logic        last_param;
   } req_type;

   // result item: the whole pen plus the malformed flag
   typedef struct packed {
      logic [1:0]  fg_kind;
      logic [23:0] fg_value;
      logic [1:0]  bg_kind;
      logic [23:0] bg_value;
      logic [7:0]  attr_bits;
      logic        malformed;
   } rsp_type;

   // color kinds
   localparam logic [1:0] KIND_DEFAULT = 2'd0;
   localparam logic [1:0] KIND_PALETTE = 2'd1;
   localparam logic [1:0] KIND_RGB     = 2'd2;

   // attribute bits
   localparam logic [7:0] ATTR_BOLD      = 8'h01;
   localparam logic [7:0] ATTR_DIM       = 8'h02;
   localparam logic [7:0] ATTR_ITALIC    = 8'h04;
   localparam logic [7:0] ATTR_UNDERLINE = 8'h08;
   localparam logic [7:0] ATTR_BLINK     = 8'h10;
   localparam logic [7:0] ATTR_REVERSE   = 8'h20;
   localparam logic [7:0] ATTR_INVISIBLE = 8'h40;
   localparam logic [7:0] ATTR_STRIKE    = 8'h80;

   // SGR parameter codes
   localparam logic [15:0] SGR_RESET          = 16'd0;
   localparam logic [15:0] SGR_BOLD           = 16'd1;
   localparam logic [15:0] SGR_DIM            = 16'd2;
   localparam logic [15:0] SGR_ITALIC         = 16'd3;
   localparam logic [15:0] SGR_UNDERLINE      = 16'd4;
   localparam logic [15:0] SGR_BLINK_SLOW     = 16'd5;
   localparam logic [15:0] SGR_BLINK_FAST     = 16'd6;
   localparam logic [15:0] SGR_REVERSE        = 16'd7;
   localparam logic [15:0] SGR_INVISIBLE      = 16'd8;
   localparam logic [15:0] SGR_STRIKE         = 16'd9;
   localparam logic [15:0] SGR_DBL_UNDERLINE  = 16'd21;
   localparam logic [15:0] SGR_NORMAL         = 16'd22;
   localparam logic [15:0] SGR_NO_ITALIC      = 16'd23;
   localparam logic [15:0] SGR_NO_UNDERLINE   = 16'd24;
   localparam logic [15:0] SGR_NO_BLINK       = 16'd25;
   localparam logic [15:0] SGR_NO_REVERSE     = 16'd27;
   localparam logic [15:0] SGR_NO_INVISIBLE   = 16'd28;
   localparam logic [15:0] SGR_NO_STRIKE      = 16'd29;
   localparam logic [15:0] SGR_FG_BASE        = 16'd30;
   localparam logic [15:0] SGR_EXT_FG         = 16'd38;
   localparam logic [15:0] SGR_FG_DEFAULT     = 16'd39;
   localparam logic [15:0] SGR_BG_BASE        = 16'd40;
   localparam logic [15:0] SGR_EXT_BG         = 16'd48;
   localparam logic [15:0] SGR_BG_DEFAULT     = 16'd49;
   localparam logic [15:0] SGR_FG_BRIGHT_BASE = 16'd90;
   localparam logic [15:0] SGR_BG_BRIGHT_BASE = 16'd100;
   localparam logic [15:0] SGR_KIND_RGB       = 16'd2;
   localparam logic [15:0] SGR_KIND_INDEX     = 16'd5;
   localparam logic [15:0] PALETTE_SPAN       = 16'd8;
   localparam logic [15:0] BRIGHT_OFFSET      = 16'd8;

   // commands from decoder to executor
   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_RESET_ALL,
      CMD_ATTR_SET,
      CMD_ATTR_CLR,
      CMD_COLOR_DEFAULT,
      CMD_COLOR_PALETTE,
      CMD_HOLD_RED,
      CMD_HOLD_GREEN,
      CMD_COLOR_RGB
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       background;
      logic [7:0] value;      // attribute mask, palette index or color byte
      logic       malformed;
   } cmd_type;

   // command queue depth
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

endpackage
`default_nettype wire

// File: hdl/sgr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_front
// Decoder: tracks the extended color phase and turns each parameter into a
// pen command plus malformed flag, one per accepted transfer.
// ----------------------------------------------------------------------------
module sgr_front
   import sgr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req_data,
   output cmd_type      cmd
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_KIND,
      PH_INDEX,
      PH_RED,
      PH_GREEN,
      PH_BLUE,
      PH_SKIP
   } phase_type;

   phase_type phase_ff, phase_in;
   logic      target_bg_ff, target_bg_in;
   logic [15:0] p;

   assign p = req_data.param_value;

   // plain codes and phase walk
   always_comb begin
      phase_in       = phase_ff;
      target_bg_in   = target_bg_ff;
      cmd.op         = CMD_NOP;
      cmd.background = target_bg_ff;
      cmd.value      = p[7:0];
      cmd.malformed  = 1'b0;
      case (phase_ff)
         PH_KIND: begin
            if (p == SGR_KIND_INDEX) begin
               phase_in = PH_INDEX;
            end else if (p == SGR_KIND_RGB) begin
               phase_in = PH_RED;
            end else begin
               phase_in      = PH_SKIP;
               cmd.malformed = 1'b1;
            end
         end
         PH_INDEX: begin
            cmd.op   = CMD_COLOR_PALETTE;
            phase_in = PH_IDLE;
         end
         PH_RED: begin
            cmd.op   = CMD_HOLD_RED;
            phase_in = PH_GREEN;
         end
         PH_GREEN: begin
            cmd.op   = CMD_HOLD_GREEN;
            phase_in = PH_BLUE;
         end
         PH_BLUE: begin
            cmd.op   = CMD_COLOR_RGB;
            phase_in = PH_IDLE;
         end
         PH_SKIP: begin
            cmd.op = CMD_NOP;
         end
         default: begin
            if (p == SGR_EXT_FG || p == SGR_EXT_BG) begin
               target_bg_in = (p == SGR_EXT_BG);
               phase_in     = PH_KIND;
            end else begin
               case (p)
                  SGR_RESET: cmd.op = CMD_RESET_ALL;
                  SGR_BOLD: begin
                     cmd.op = CMD_ATTR_SET; cmd.value = ATTR_BOLD;
                  end
                  SGR_DIM: begin
                     cmd.op = CMD_ATTR_SET; cmd.value = ATTR_DIM;
                  end
                  SGR_ITALIC: begin
                     cmd.op = CMD_ATTR_SET; cmd.value = ATTR_ITALIC;
                  end
                  SGR_UNDERLINE: begin
                     cmd.op = CMD_ATTR_SET; cmd.value = ATTR_UNDERLINE;
                  end
                  SGR_BLINK_SLOW, SGR_BLINK_FAST: begin
                     cmd.op = CMD_ATTR_SET; cmd.value = ATTR_BLINK;
                  end
                  SGR_REVERSE: begin
                     cmd.op = CMD_ATTR_SET; cmd.value = ATTR_REVERSE;
                  end
                  SGR_INVISIBLE: begin
                     cmd.op = CMD_ATTR_SET; cmd.value = ATTR_INVISIBLE;
                  end
                  SGR_STRIKE: begin
                     cmd.op = CMD_ATTR_SET; cmd.value = ATTR_STRIKE;
                  end
                  SGR_DBL_UNDERLINE, SGR_NORMAL: begin
                     cmd.op = CMD_ATTR_CLR; cmd.value = ATTR_BOLD | ATTR_DIM;
                  end
                  SGR_NO_ITALIC: begin
                     cmd.op = CMD_ATTR_CLR; cmd.value = ATTR_ITALIC;
                  end
                  SGR_NO_UNDERLINE: begin
                     cmd.op = CMD_ATTR_CLR; cmd.value = ATTR_UNDERLINE;
                  end
                  SGR_NO_BLINK: begin
                     cmd.op = CMD_ATTR_CLR; cmd.value = ATTR_BLINK;
                  end
                  SGR_NO_REVERSE: begin
                     cmd.op = CMD_ATTR_CLR; cmd.value = ATTR_REVERSE;
                  end
                  SGR_NO_INVISIBLE: begin
                     cmd.op = CMD_ATTR_CLR; cmd.value = ATTR_INVISIBLE;
                  end
                  SGR_NO_STRIKE: begin
                     cmd.op = CMD_ATTR_CLR; cmd.value = ATTR_STRIKE;
                  end
                  SGR_FG_DEFAULT: begin
                     cmd.op = CMD_COLOR_DEFAULT; cmd.background = 1'b0;
                  end
                  SGR_BG_DEFAULT: begin
                     cmd.op = CMD_COLOR_DEFAULT; cmd.background = 1'b1;
                  end
                  default: begin
                     // palette ranges, normal and bright
                     if (p >= SGR_FG_BASE && p < SGR_FG_BASE + PALETTE_SPAN) begin
                        cmd.op         = CMD_COLOR_PALETTE;
                        cmd.background = 1'b0;
                        cmd.value      = 8'(p - SGR_FG_BASE);
                     end else if (p >= SGR_BG_BASE && p < SGR_BG_BASE + PALETTE_SPAN) begin
                        cmd.op         = CMD_COLOR_PALETTE;
                        cmd.background = 1'b1;
                        cmd.value      = 8'(p - SGR_BG_BASE);
                     end else if (p >= SGR_FG_BRIGHT_BASE
                                  && p < SGR_FG_BRIGHT_BASE + PALETTE_SPAN) begin
                        cmd.op         = CMD_COLOR_PALETTE;
                        cmd.background = 1'b0;
                        cmd.value      = 8'(p - SGR_FG_BRIGHT_BASE + BRIGHT_OFFSET);
                     end else if (p >= SGR_BG_BRIGHT_BASE
                                  && p < SGR_BG_BRIGHT_BASE + PALETTE_SPAN) begin
                        cmd.op         = CMD_COLOR_PALETTE;
                        cmd.background = 1'b1;
                        cmd.value      = 8'(p - SGR_BG_BRIGHT_BASE + BRIGHT_OFFSET);
                     end
                  end
               endcase
            end
         end
      endcase

      // end of sequence: flag an unfinished extended color
      if (req_data.last_param) begin
         if (phase_in != PH_IDLE && phase_in != PH_SKIP) begin
            cmd.malformed = 1'b1;
         end
         phase_in = PH_IDLE;
      end
   end

   // phase registers advance on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         target_bg_ff <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         target_bg_ff <= target_bg_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/sgr_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_cmd_queue
// Short command queue between decoder and executor; a push and a pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module sgr_cmd_queue
   import sgr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         empty
);

   cmd_type              entries_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: hdl/sgr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_back
// Executor: applies queued commands to the kept pen and registers the pen
// with the malformed flag as the result of each transfer.
// ----------------------------------------------------------------------------
module sgr_back
   import sgr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire logic    cmd_empty,
   output logic         cmd_pop,
   output rsp_type      rsp_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop
);

   rsp_type    pen_ff, pen_in;
   logic [7:0] held_red_ff, held_red_in;
   logic [7:0] held_green_ff, held_green_in;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff;

   // take a command when the result register is free or being drained
   assign cmd_pop   = !cmd_empty && (!rsp_valid_ff || rsp_pop);
   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;

   // pen update for one command
   always_comb begin
      pen_in           = pen_ff;
      pen_in.malformed = cmd.malformed;
      held_red_in      = held_red_ff;
      held_green_in    = held_green_ff;
      case (cmd.op)
         CMD_RESET_ALL: begin
            pen_in.fg_kind   = KIND_DEFAULT;
            pen_in.fg_value  = '0;
            pen_in.bg_kind   = KIND_DEFAULT;
            pen_in.bg_value  = '0;
            pen_in.attr_bits = '0;
         end
         CMD_ATTR_SET: pen_in.attr_bits = pen_ff.attr_bits | cmd.value;
         CMD_ATTR_CLR: pen_in.attr_bits = pen_ff.attr_bits & ~cmd.value;
         CMD_COLOR_DEFAULT: begin
            if (cmd.background) begin
               pen_in.bg_kind  = KIND_DEFAULT;
               pen_in.bg_value = '0;
            end else begin
               pen_in.fg_kind  = KIND_DEFAULT;
               pen_in.fg_value = '0;
            end
         end
         CMD_COLOR_PALETTE: begin
            if (cmd.background) begin
               pen_in.bg_kind  = KIND_PALETTE;
               pen_in.bg_value = {16'd0, cmd.value};
            end else begin
               pen_in.fg_kind  = KIND_PALETTE;
               pen_in.fg_value = {16'd0, cmd.value};
            end
         end
         CMD_HOLD_RED:   held_red_in   = cmd.value;
         CMD_HOLD_GREEN: held_green_in = cmd.value;
         CMD_COLOR_RGB: begin
            if (cmd.background) begin
               pen_in.bg_kind  = KIND_RGB;
               pen_in.bg_value = {held_red_ff, held_green_ff, cmd.value};
            end else begin
               pen_in.fg_kind  = KIND_RGB;
               pen_in.fg_value = {held_red_ff, held_green_ff, cmd.value};
            end
         end
         default: begin
            pen_in.malformed = cmd.malformed;
         end
      endcase
   end

   // kept pen and held rgb bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff        <= '0;
         held_red_ff   <= '0;
         held_green_ff <= '0;
      end else if (cmd_pop) begin
         pen_ff        <= pen_in;
         held_red_ff   <= held_red_in;
         held_green_ff <= held_green_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_ff <= pen_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/sgr_pen_attribute_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_pen_attribute_parser_core
// Parses SGR parameters one per transfer and keeps the current pen.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive req_data (param_value, last_param) and raise
//   req_push; a transfer happens at a clock edge with req_push high and
//   req_full low. Each parameter yields exactly one result.
//   Result queue side: while rsp_empty is low, rsp_data holds the oldest
//   pen (colors, attributes, malformed flag); raise rsp_pop to take it.
//   Path: each parameter is decoded into the command queue at its transfer
//   edge; the pen update then goes into the result register once that
//   register is free or being drained. Throughput is one parameter per
//   cycle while the receiver drains results, set by the phase register in
//   the decoder and the pen update.
//   If the receiver stalls, the result register holds, the two-entry
//   command queue fills and req_full rises within two further transfers.
//   Reset (synchronous, active high) clears the pen to defaults with no
//   attributes, returns the decoder to the idle phase and empties the
//   queue and the result register.
// ----------------------------------------------------------------------------
module sgr_pen_attribute_parser_core
   import sgr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    accept;
   logic    queue_empty;
   logic    queue_pop;

   assign accept = req_push && !req_full;

   // decoder
   sgr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   // decoupling queue
   sgr_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_data  (queue_cmd),
      .empty     (queue_empty)
   );

   // executor
   sgr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (queue_cmd),
      .cmd_empty (queue_empty),
      .cmd_pop   (queue_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule
`default_nettype wire
